[src/nmea_rmc_pkg.sv]
// Shared types, character codes and constant tables for the RMC position extractor.
// Used by nmea_rmc_parser, nmea_rmc_deg_conv and nmea_rmc_position_extractor_top.
package nmea_rmc_pkg;

    localparam int ACC_W      = 31;
    localparam int FRAC_CNT_W = 4;
    localparam int CONV_STAGES = 8;

    localparam logic [2:0] PREFIX_LEN = 3'd6;
    localparam logic [3:0] COMMA_MAX  = 4'd15;
    localparam logic [3:0] LAT_FIELD  = 4'd3;
    localparam logic [3:0] LON_FIELD  = 4'd5;

    localparam logic [ACC_W-1:0] ACC_MAX   = 31'h7FFF_FFFF;
    localparam logic [ACC_W-1:0] OUT_MAX   = 31'd1800000000;
    localparam logic [63:0]      OUT_SCALE = 64'd10000000;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_PREFIX = 3'd1,
        ST_FIELDS = 3'd2,
        ST_EMPTY  = 3'd3,
        ST_NUMBER = 3'd4
    } t_status;

    // Everything the converter needs about one finished line.
    typedef struct packed {
        t_status                 status;
        logic [ACC_W-1:0]        lat_acc;
        logic [FRAC_CNT_W-1:0]   lat_frac;
        logic [ACC_W-1:0]        lon_acc;
        logic [FRAC_CNT_W-1:0]   lon_frac;
    } t_snap;

    // Expected "$GNRMC" character at a prefix position.
    function automatic logic [7:0] prefix_char(input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = 8'h24;   // $
            3'd1:    ch = 8'h47;   // G
            3'd2:    ch = 8'h4E;   // N
            3'd3:    ch = 8'h52;   // R
            3'd4:    ch = 8'h4D;   // M
            3'd5:    ch = 8'h43;   // C
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Powers of ten, 10^0 .. 10^8.
    function automatic logic [63:0] pow10(input logic [3:0] n);
        logic [63:0] p;
        unique case (n)
            4'd0:    p = 64'd1;
            4'd1:    p = 64'd10;
            4'd2:    p = 64'd100;
            4'd3:    p = 64'd1000;
            4'd4:    p = 64'd10000;
            4'd5:    p = 64'd100000;
            4'd6:    p = 64'd1000000;
            4'd7:    p = 64'd10000000;
            4'd8:    p = 64'd100000000;
            default: p = 64'd0;
        endcase
        return p;
    endfunction

endpackage

[src/nmea_rmc_parser.sv]
// Per-character sentence state: prefix check, comma count, coordinate accumulators.
// Depends on nmea_rmc_pkg; gives the line snapshot for the transaction that ends a line.
module nmea_rmc_parser
    import nmea_rmc_pkg::*;
#(
    parameter int FRACTION_DIGITS = 5
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_char_byte,
    input  logic       i_end_of_line,
    output t_snap      o_snap
);

    localparam logic [FRAC_CNT_W-1:0] FRAC_LIM = FRAC_CNT_W'(FRACTION_DIGITS);

    logic [2:0]            r_pos,        n_pos;
    logic                  r_prefix_bad, n_prefix_bad;
    logic [3:0]            r_comma,      n_comma;
    logic [ACC_W-1:0]      r_lat_acc,    n_lat_acc;
    logic [ACC_W-1:0]      r_lon_acc,    n_lon_acc;
    logic [FRAC_CNT_W-1:0] r_lat_frac,   n_lat_frac;
    logic [FRAC_CNT_W-1:0] r_lon_frac,   n_lon_frac;
    logic                  r_lat_point,  n_lat_point;
    logic                  r_lon_point,  n_lon_point;
    logic                  r_lat_present, n_lat_present;
    logic                  r_lon_present, n_lon_present;
    logic                  r_num_bad,    n_num_bad;

    // Feed path for whichever coordinate field is open
    logic                  in_lat;
    logic [ACC_W-1:0]      sel_acc,   f_acc;
    logic [FRAC_CNT_W-1:0] sel_frac,  f_frac;
    logic                  sel_point, f_point;
    logic                  f_bad;
    logic                  is_digit;
    logic [34:0]           shifted;
    t_status               status;

    assign in_lat    = (r_comma == LAT_FIELD);
    assign sel_acc   = in_lat ? r_lat_acc   : r_lon_acc;
    assign sel_frac  = in_lat ? r_lat_frac  : r_lon_frac;
    assign sel_point = in_lat ? r_lat_point : r_lon_point;
    assign is_digit  = (i_char_byte >= CH_ZERO) && (i_char_byte <= CH_NINE);
    assign shifted   = 35'(sel_acc) * 35'd10 + 35'(i_char_byte - CH_ZERO);

    always_comb begin
        f_acc   = sel_acc;
        f_frac  = sel_frac;
        f_point = sel_point;
        f_bad   = 1'b0;
        if (is_digit) begin
            if (!sel_point || (sel_frac < FRAC_LIM)) begin
                f_acc = (shifted > 35'(ACC_MAX)) ? ACC_MAX : shifted[ACC_W-1:0];
            end
            if (sel_point && (sel_frac < FRAC_LIM)) begin
                f_frac = sel_frac + 1'b1;
            end
        end else if (i_char_byte == CH_POINT) begin
            if (sel_point) begin
                f_bad = 1'b1;
            end
            f_point = 1'b1;
        end else begin
            f_bad = 1'b1;
        end
    end

    always_comb begin
        n_pos         = r_pos;
        n_prefix_bad  = r_prefix_bad;
        n_comma       = r_comma;
        n_lat_acc     = r_lat_acc;
        n_lon_acc     = r_lon_acc;
        n_lat_frac    = r_lat_frac;
        n_lon_frac    = r_lon_frac;
        n_lat_point   = r_lat_point;
        n_lon_point   = r_lon_point;
        n_lat_present = r_lat_present;
        n_lon_present = r_lon_present;
        n_num_bad     = r_num_bad;
        if (i_accept && (i_char_byte != CH_CR) && (i_char_byte != CH_LF)) begin
            if (r_pos < PREFIX_LEN) begin
                if (i_char_byte != prefix_char(r_pos)) begin
                    n_prefix_bad = 1'b1;
                end
                n_pos = r_pos + 1'b1;
            end
            if (i_char_byte == CH_COMMA) begin
                if (r_comma != COMMA_MAX) begin
                    n_comma = r_comma + 1'b1;
                end
            end else if (r_comma == LAT_FIELD) begin
                n_lat_present = 1'b1;
                n_lat_acc     = f_acc;
                n_lat_frac    = f_frac;
                n_lat_point   = f_point;
                n_num_bad     = r_num_bad | f_bad;
            end else if (r_comma == LON_FIELD) begin
                n_lon_present = 1'b1;
                n_lon_acc     = f_acc;
                n_lon_frac    = f_frac;
                n_lon_point   = f_point;
                n_num_bad     = r_num_bad | f_bad;
            end
        end
    end

    // Status of the line as it stands after the current character
    always_comb begin
        priority if (n_prefix_bad || (n_pos < PREFIX_LEN)) begin
            status = ST_PREFIX;
        end else if ((n_comma < LON_FIELD) || ((n_comma == LON_FIELD) && !n_lon_present)) begin
            status = ST_FIELDS;
        end else if (!n_lat_present || !n_lon_present) begin
            status = ST_EMPTY;
        end else if (n_num_bad) begin
            status = ST_NUMBER;
        end else begin
            status = ST_OK;
        end
    end

    assign o_snap.status   = status;
    assign o_snap.lat_acc  = n_lat_acc;
    assign o_snap.lat_frac = n_lat_frac;
    assign o_snap.lon_acc  = n_lon_acc;
    assign o_snap.lon_frac = n_lon_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_end_of_line)) begin
            r_pos         <= '0;
            r_prefix_bad  <= 1'b0;
            r_comma       <= '0;
            r_lat_acc     <= '0;
            r_lon_acc     <= '0;
            r_lat_frac    <= '0;
            r_lon_frac    <= '0;
            r_lat_point   <= 1'b0;
            r_lon_point   <= 1'b0;
            r_lat_present <= 1'b0;
            r_lon_present <= 1'b0;
            r_num_bad     <= 1'b0;
        end else begin
            r_pos         <= n_pos;
            r_prefix_bad  <= n_prefix_bad;
            r_comma       <= n_comma;
            r_lat_acc     <= n_lat_acc;
            r_lon_acc     <= n_lon_acc;
            r_lat_frac    <= n_lat_frac;
            r_lon_frac    <= n_lon_frac;
            r_lat_point   <= n_lat_point;
            r_lon_point   <= n_lon_point;
            r_lat_present <= n_lat_present;
            r_lon_present <= n_lon_present;
            r_num_bad     <= n_num_bad;
        end
    end

endmodule

[src/nmea_rmc_deg_conv.sv]
// Eight-stage pipeline: fixed-point ddmm.mmmm value to degrees times 10^7, saturated.
// Depends on nmea_rmc_pkg; stage enables come from the top-level valid chain.
module nmea_rmc_deg_conv
    import nmea_rmc_pkg::*;
#(
    parameter int FRACTION_DIGITS = 5
) (
    input  logic                   i_clk,
    input  logic [CONV_STAGES-1:0] i_en,
    input  logic [ACC_W-1:0]       i_acc,
    input  logic [FRAC_CNT_W-1:0]  i_frac,
    output logic [ACC_W-1:0]       o_value
);

    localparam logic [63:0] SCALE = pow10(4'(FRACTION_DIGITS));
    localparam logic [63:0] HUND  = 64'd100 * SCALE;
    localparam logic [63:0] M1    = (64'd1 << 32) / HUND;
    // Common power of ten removed from minutes * 10^7 / (60 * scale)
    localparam int          G     = (FRACTION_DIGITS + 1 < 7) ? FRACTION_DIGITS + 1 : 7;
    localparam logic [63:0] NF    = pow10(4'(7 - G));
    localparam logic [63:0] DF    = 64'd6 * pow10(4'(FRACTION_DIGITS + 1 - G));
    localparam logic [63:0] M2    = (64'd1 << 32) / DF;

    // Stage 1: pad missing fraction digits
    logic [26:0]      pad_fac;
    logic [57:0]      pad_prod;
    logic [ACC_W-1:0] r_s1_v;
    // Stage 2: estimated whole degrees
    logic [63:0]      est1_prod;
    logic [ACC_W-1:0] r_s2_v, r_s2_q;
    // Stage 3: remainder (minutes, scaled)
    logic [ACC_W-1:0] r_s3_q, r_s3_rem;
    // Stage 4: one correction step
    logic [ACC_W-1:0] r_s4_q, r_s4_m;
    // Stage 5: scaled minutes and degree term
    logic [63:0]      deg_term;
    logic [ACC_W-1:0] r_s5_p, r_s5_dterm;
    // Stage 6: estimated minutes quotient
    logic [63:0]      est2_prod;
    logic [ACC_W-1:0] r_s6_p, r_s6_q2, r_s6_dterm;
    // Stage 7: quotient remainder
    logic [ACC_W-1:0] r_s7_q2, r_s7_r2, r_s7_dterm;
    // Stage 8: final sum and saturation
    logic [31:0]      sum;
    logic [ACC_W-1:0] r_s8_out;

    assign pad_fac   = 27'(pow10(4'(FRACTION_DIGITS) - i_frac));
    assign pad_prod  = 58'(i_acc) * 58'(pad_fac);
    assign est1_prod = 64'(r_s1_v) * 64'(M1[31:0]);
    assign deg_term  = 64'(r_s4_q) * OUT_SCALE;
    assign est2_prod = 64'(r_s5_p) * 64'(M2[31:0]);
    assign sum       = 32'(r_s7_dterm) + 32'(r_s7_q2)
                       + ((64'(r_s7_r2) >= DF) ? 32'd1 : 32'd0);

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_v <= (pad_prod > 58'(ACC_MAX)) ? ACC_MAX : pad_prod[ACC_W-1:0];
        end
        if (i_en[1]) begin
            r_s2_v <= r_s1_v;
            r_s2_q <= est1_prod[62:32];
        end
        if (i_en[2]) begin
            r_s3_q   <= r_s2_q;
            r_s3_rem <= ACC_W'(64'(r_s2_v) - 64'(r_s2_q) * HUND);
        end
        if (i_en[3]) begin
            if (64'(r_s3_rem) >= HUND) begin
                r_s4_q <= r_s3_q + 1'b1;
                r_s4_m <= ACC_W'(64'(r_s3_rem) - HUND);
            end else begin
                r_s4_q <= r_s3_q;
                r_s4_m <= r_s3_rem;
            end
        end
        if (i_en[4]) begin
            r_s5_p     <= ACC_W'(64'(r_s4_m) * NF);
            // Clamp just above the output limit; the final stage saturates.
            r_s5_dterm <= (deg_term > 64'(OUT_MAX)) ? OUT_MAX + 1'b1 : deg_term[ACC_W-1:0];
        end
        if (i_en[5]) begin
            r_s6_p     <= r_s5_p;
            r_s6_q2    <= est2_prod[62:32];
            r_s6_dterm <= r_s5_dterm;
        end
        if (i_en[6]) begin
            r_s7_q2    <= r_s6_q2;
            r_s7_r2    <= ACC_W'(64'(r_s6_p) - 64'(r_s6_q2) * DF);
            r_s7_dterm <= r_s6_dterm;
        end
        if (i_en[7]) begin
            r_s8_out <= (sum > 32'(OUT_MAX)) ? OUT_MAX : sum[ACC_W-1:0];
        end
    end

    assign o_value = r_s8_out;

endmodule

[src/nmea_rmc_position_extractor_top.sv]
// Top level of the RMC position extractor: handshakes, line snapshot, result pipeline.
// Depends on nmea_rmc_pkg, nmea_rmc_parser and nmea_rmc_deg_conv.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one character per transaction,
//   i_char_byte plus i_end_of_line marking the last character of a line.
//   Output channel (o_valid / i_ready) carries one result per line: o_status
//   and both coordinates in degrees times 10^7 (zero unless status is OK).
//   Throughput: one character per cycle, sustained, including back-to-back
//   lines, unless a receiver stall fills the pipeline. Per-character work
//   is one compare set and one multiply by ten in the parser.
//   Result path: the end-of-line transaction loads the snapshot register;
//   the result then passes the eight stages of the degree conversion (pad,
//   two reciprocal divides with correction, sum) to o_valid.
//   Reset (synchronous, active low) clears all line state and every pipeline
//   valid; no clearing pass is needed.
//   Receiver stall: each pipeline stage holds only while the stage after it
//   is full, so characters keep flowing until every slot between the snapshot
//   register and the output register holds a pending line.
module nmea_rmc_position_extractor_top
    import nmea_rmc_pkg::*;
#(
    parameter int FRACTION_DIGITS = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_char_byte,
    input  logic             i_end_of_line,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [2:0]       o_status,
    output logic [ACC_W-1:0] o_latitude_value,
    output logic [ACC_W-1:0] o_longitude_value
);

    logic                   accept;
    logic [CONV_STAGES:0]   stage_en;     // stage k may load this cycle
    logic [CONV_STAGES:0]   r_valid;      // stage 0 is the snapshot register
    t_status                r_stat [1:CONV_STAGES];
    t_snap                  snap;
    t_snap                  r_snap;
    logic [ACC_W-1:0]       lat_deg, lon_deg;

    assign accept  = i_valid && o_ready;
    assign o_ready = stage_en[0];

    // Enable ripples back from the output register: a stage loads when it is
    // empty or its contents move on this cycle.
    always_comb begin
        stage_en[CONV_STAGES] = !r_valid[CONV_STAGES] || i_ready;
        for (int k = CONV_STAGES - 1; k >= 0; k--) begin
            stage_en[k] = !r_valid[k] || stage_en[k+1];
        end
    end

    nmea_rmc_parser #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_char_byte   (i_char_byte),
        .i_end_of_line (i_end_of_line),
        .o_snap        (snap)
    );

    // Snapshot register (stage 0, loaded by the end-of-line transaction);
    // valid travels alongside the conversion stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (accept && i_end_of_line) begin
                r_valid[0] <= 1'b1;
            end else if (stage_en[1]) begin
                r_valid[0] <= 1'b0;
            end
            for (int k = 1; k <= CONV_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_valid[k] <= r_valid[k-1];
                end
            end
        end
        if (accept && i_end_of_line) begin
            r_snap <= snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_stat[1] <= r_snap.status;
        end
        for (int k = 2; k <= CONV_STAGES; k++) begin
            if (stage_en[k]) begin
                r_stat[k] <= r_stat[k-1];
            end
        end
    end

    nmea_rmc_deg_conv #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_lat_conv (
        .i_clk   (i_clk),
        .i_en    (stage_en[CONV_STAGES:1]),
        .i_acc   (r_snap.lat_acc),
        .i_frac  (r_snap.lat_frac),
        .o_value (lat_deg)
    );

    nmea_rmc_deg_conv #(
        .FRACTION_DIGITS (FRACTION_DIGITS)
    ) u_lon_conv (
        .i_clk   (i_clk),
        .i_en    (stage_en[CONV_STAGES:1]),
        .i_acc   (r_snap.lon_acc),
        .i_frac  (r_snap.lon_frac),
        .o_value (lon_deg)
    );

    // Coordinates are reported only for a clean line
    assign o_valid           = r_valid[CONV_STAGES];
    assign o_status          = r_stat[CONV_STAGES];
    assign o_latitude_value  = (r_stat[CONV_STAGES] == ST_OK) ? lat_deg : '0;
    assign o_longitude_value = (r_stat[CONV_STAGES] == ST_OK) ? lon_deg : '0;

endmodule
